/* hw/rtl/edd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the escape dictionary decompressor.
package edd_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int NUM_IDS     = 256;
   localparam int OUT_LIMIT   = 64;
   localparam int OFF_W       = 6;
   localparam int ID_W        = $clog2(NUM_IDS);
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int CNT_W       = $clog2(OUT_LIMIT + 1);
   localparam int STORE_DEPTH = (NUM_IDS - 1) * MAX_PATTERN;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam logic [7:0] ESC_BYTE = 8'hFF;
   localparam logic [7:0] KEY_LITERAL = 8'h00;

   localparam logic [1:0] OP_DICT   = 2'd0;
   localparam logic [1:0] OP_STREAM = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_BAD_ENTRY = 3'd1;
   localparam logic [2:0] STS_DANGLING  = 3'd2;
   localparam logic [2:0] STS_UNDEF_KEY = 3'd3;
   localparam logic [2:0] STS_MISMATCH  = 3'd4;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_EMIT
   } state_type;

   typedef struct packed {
      logic             wr_en;
      logic [ID_W-1:0]  wr_addr;
      logic [LEN_W-1:0] wr_len;
      logic             rd_en;
      logic [ID_W-1:0]  rd_addr;
   } len_req_type;

   typedef struct packed {
      logic                wr_en;
      logic [STORE_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic                rd_en;
      logic [STORE_AW-1:0] rd_addr;
   } pat_req_type;

   function automatic logic [STORE_AW-1:0] pat_addr(logic [7:0] id, logic [OFF_W-1:0] off);
      return STORE_AW'((int'(id) - 1) * MAX_PATTERN + int'(off));
   endfunction

endpackage

/* hw/rtl/edd_len_table.sv */
`timescale 1ns / 1ps
// Pattern length memory with per-entry valid bits cleared at reset.
module edd_len_table
   import edd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  len_req_type       len_req,
   output logic [LEN_W-1:0]  rd_len
);

   logic [LEN_W-1:0] mem [NUM_IDS];
   logic [NUM_IDS-1:0] valid_ff;
   logic [LEN_W-1:0] rd_len_ff;

   always_ff @(posedge clock) begin
      if (len_req.wr_en) begin
         mem[len_req.wr_addr] <= len_req.wr_len;
      end
      if (len_req.rd_en) begin
         rd_len_ff <= valid_ff[len_req.rd_addr] ? mem[len_req.rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (len_req.wr_en) begin
         valid_ff[len_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_len = rd_len_ff;

endmodule

/* hw/rtl/edd_pat_store.sv */
`timescale 1ns / 1ps
// Pattern byte memory, one write and one registered read per cycle.
module edd_pat_store
   import edd_pkg::*;
(
   input  logic        clock,
   input  pat_req_type pat_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (pat_req.wr_en) begin
         mem[pat_req.wr_addr] <= pat_req.wr_data;
      end
      if (pat_req.rd_en) begin
         rd_data_ff <= mem[pat_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/edd_ctrl.sv */
`timescale 1ns / 1ps
// Decode sequencer: stream state, pattern expansion and result register.
module edd_ctrl
   import edd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [7:0]        req_pattern_id,
   input  logic [7:0]        req_pattern_length,
   input  logic [5:0]        req_pattern_offset,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_status,
   output logic [2:0]        rsp_status,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [63:0]       csr_expected_size,
   output len_req_type       len_req,
   input  logic [LEN_W-1:0]  len_rd,
   output pat_req_type       pat_req,
   input  logic [7:0]        pat_rd
);

   state_type state_ff, state_in;
   logic             esc_ff, esc_in;
   logic [2:0]       err_ff, err_in;
   logic [63:0]      count_ff, count_in;
   logic [63:0]      size_ff;
   logic [7:0]       key_ff, key_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [OFF_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_is_status_ff, rsp_is_status_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic out_free;
   logic accept;
   logic bad_entry;
   logic expand_start;
   logic key_bad;
   logic emit_last;
   logic [2:0] end_status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign bad_entry = (req_pattern_id == 8'd0) || (int'(req_pattern_id) >= NUM_IDS)
                   || (req_pattern_length == 8'd0) || (int'(req_pattern_length) > MAX_PATTERN);
   assign expand_start = accept && (req_operation == OP_STREAM) && (err_ff == STS_OK)
                      && esc_ff && (req_data_byte != KEY_LITERAL);
   assign key_bad   = (len_rd == '0) || (int'(key_ff) >= NUM_IDS);
   assign emit_last = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;

   always_comb begin
      if (err_ff != STS_OK) begin
         end_status = err_ff;
      end else if (esc_ff) begin
         end_status = STS_DANGLING;
      end else if (count_ff != size_ff) begin
         end_status = STS_MISMATCH;
      end else begin
         end_status = STS_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (expand_start) begin
               state_in = FSM_LOOKUP;
            end
         end
         FSM_LOOKUP: begin
            state_in = key_bad ? FSM_IDLE : FSM_EMIT;
         end
         FSM_EMIT: begin
            if (out_free && emit_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      esc_in           = esc_ff;
      err_in           = err_ff;
      count_in         = count_ff;
      key_in           = key_ff;
      n_in             = n_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_byte_in      = rsp_byte_ff;
      rsp_is_status_in = rsp_is_status_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      len_req          = '0;
      pat_req          = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_DICT: begin
                     if (err_ff == STS_OK) begin
                        if (bad_entry) begin
                           err_in = STS_BAD_ENTRY;
                        end else begin
                           len_req.wr_en   = 1'b1;
                           len_req.wr_addr = ID_W'(req_pattern_id);
                           len_req.wr_len  = LEN_W'(req_pattern_length);
                           pat_req.wr_en   = {2'b00, req_pattern_offset} < req_pattern_length;
                           pat_req.wr_addr = pat_addr(req_pattern_id, req_pattern_offset);
                           pat_req.wr_data = req_data_byte;
                        end
                     end
                  end
                  OP_STREAM: begin
                     if (err_ff == STS_OK) begin
                        if (!esc_ff) begin
                           if (req_data_byte == ESC_BYTE) begin
                              esc_in = 1'b1;
                           end else begin
                              rsp_valid_in     = 1'b1;
                              rsp_byte_in      = req_data_byte;
                              rsp_is_status_in = 1'b0;
                              rsp_status_in    = STS_OK;
                              rsp_last_in      = 1'b1;
                              count_in         = count_ff + 64'd1;
                           end
                        end else begin
                           esc_in = 1'b0;
                           if (req_data_byte == KEY_LITERAL) begin
                              rsp_valid_in     = 1'b1;
                              rsp_byte_in      = ESC_BYTE;
                              rsp_is_status_in = 1'b0;
                              rsp_status_in    = STS_OK;
                              rsp_last_in      = 1'b1;
                              count_in         = count_ff + 64'd1;
                           end else begin
                              key_in          = req_data_byte;
                              len_req.rd_en   = 1'b1;
                              len_req.rd_addr = ID_W'(req_data_byte);
                              pat_req.rd_en   = 1'b1;
                              pat_req.rd_addr = pat_addr(req_data_byte, '0);
                           end
                        end
                     end
                  end
                  OP_END: begin
                     rsp_valid_in     = 1'b1;
                     rsp_byte_in      = 8'h00;
                     rsp_is_status_in = 1'b1;
                     rsp_status_in    = end_status;
                     rsp_last_in      = 1'b1;
                     esc_in           = 1'b0;
                     count_in         = '0;
                     err_in           = STS_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_LOOKUP: begin
            if (key_bad) begin
               err_in = STS_UNDEF_KEY;
            end else begin
               n_in   = (int'(len_rd) > OUT_LIMIT) ? CNT_W'(OUT_LIMIT) : CNT_W'(len_rd);
               idx_in = '0;
            end
         end
         FSM_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_byte_in      = pat_rd;
               rsp_is_status_in = 1'b0;
               rsp_status_in    = STS_OK;
               rsp_last_in      = emit_last;
               count_in         = count_ff + 64'd1;
               if (!emit_last) begin
                  idx_in          = idx_ff + OFF_W'(1);
                  pat_req.rd_en   = 1'b1;
                  pat_req.rd_addr = pat_addr(key_ff, idx_ff + OFF_W'(1));
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         esc_ff       <= 1'b0;
         err_ff       <= STS_OK;
         count_ff     <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_expected_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff           <= key_in;
      n_ff             <= n_in;
      idx_ff           <= idx_in;
      rsp_byte_ff      <= rsp_byte_in;
      rsp_is_status_ff <= rsp_is_status_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_is_status = rsp_is_status_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* hw/rtl/escape_dictionary_decompressor_unit.sv */
`timescale 1ns / 1ps
// Top level of the escape byte dictionary substitution decoder.
//
// Dictionary writes, literal stream bytes, escape bytes and end-of-stream beats are each
// handled in a single request beat. An escaped key passes a length lookup state, then an
// emit state sends the pattern bytes in order through the single read port of the pattern
// memory. A request is held off during an expansion and while a result beat waits on a
// stalled output. The length table is valid right after reset; there is no clearing pass.
// Pattern bytes never written read as garbage.
module escape_dictionary_decompressor_unit
   import edd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_pattern_id,
   input  logic [7:0]  req_pattern_length,
   input  logic [5:0]  req_pattern_offset,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_status,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_expected_size
);

   len_req_type      len_req;
   pat_req_type      pat_req;
   logic [LEN_W-1:0] len_rd;
   logic [7:0]       pat_rd;

   edd_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_pattern_id     (req_pattern_id),
      .req_pattern_length (req_pattern_length),
      .req_pattern_offset (req_pattern_offset),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_status      (rsp_is_status),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_expected_size  (csr_expected_size),
      .len_req            (len_req),
      .len_rd             (len_rd),
      .pat_req            (pat_req),
      .pat_rd             (pat_rd)
   );

   edd_len_table u_len_table (
      .clock   (clock),
      .reset   (reset),
      .len_req (len_req),
      .rd_len  (len_rd)
   );

   edd_pat_store u_pat_store (
      .clock   (clock),
      .pat_req (pat_req),
      .rd_data (pat_rd)
   );

endmodule
